### hdl/cfr_pkg.sv
// cfr_pkg: shared types and codes for the clock frame replacer
// action codes, fixed port field widths and the beat structs passed between modules
// no dependencies
package cfr_pkg;

  // fixed widths of the stream fields
  localparam int ACTION_W = 3;
  localparam int FRAME_W  = 16;
  localparam int COUNT_W  = 7;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_VICTIM = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PIN    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNPIN  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SETEV  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SIZE   = 3'd5;

  // one request beat
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  frame_number;
    logic                evictable_flag;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [COUNT_W-1:0] occupied_count;
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_found;
  } res_t;

endpackage

### hdl/cfr_frame_ram.sv
// cfr_frame_ram: frame number store, one write and one registered read port
// no package dependencies
module cfr_frame_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/cfr_engine.sv
// cfr_engine: slot flags, hand, occupancy and the sequencer that walks the ring
// one slot is examined per cycle; uses cfr_pkg and cfr_frame_ram
module cfr_engine #(
  parameter int SLOTS      = 64,
  parameter int FRAME_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cfr_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_take,
  output cfr_pkg::res_t res
);
  import cfr_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int STEP_W = $clog2(2 * SLOTS);
  localparam int KEY_W  = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
  localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL      = CNT_W'(SLOTS);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_VREAD = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state;
  logic [SLOTS-1:0]    valid;
  logic [SLOTS-1:0]    evict;
  logic [SLOTS-1:0]    refb;
  logic [IDX_W-1:0]    hand;
  logic [CNT_W-1:0]    occupied;

  // captured request and working registers
  logic [ACTION_W-1:0] act;
  logic [KEY_W-1:0]    key;
  logic                flag;
  logic                hit;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    addr;
  logic [IDX_W-1:0]    pidx;
  logic                pend;
  logic [IDX_W-1:0]    ptr;
  logic [STEP_W-1:0]   step;
  logic                found;
  logic [KEY_W-1:0]    vframe;

  // frame store ports
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [IDX_W-1:0]    raddr;
  logic [KEY_W-1:0]    rdata;
  logic                match;
  logic [EXT_W-1:0]    occ_ext;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  cfr_frame_ram #(
    .DEPTH (SLOTS),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key),
    .raddr (raddr),
    .rdata (rdata)
  );

  // store addressing: scan counter while looking up, hand otherwise
  assign raddr = (state == S_LOOK) ? addr : hand;
  assign match = pend && valid[pidx] && (rdata == key);

  // frame write on a new unpin: at the hand when full, else at the free slot found
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    if (state == S_APPLY && act == ACT_UNPIN && !hit && occupied == FULL) begin
      we    = 1'b1;
      waddr = hand;
    end else if (state == S_FREE && !valid[ptr]) begin
      we    = 1'b1;
      waddr = ptr;
    end
  end

  // sequencer and slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      evict    <= '0;
      refb     <= '0;
      hand     <= '0;
      occupied <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            act    <= cmd.action;
            key    <= cmd.frame_number[KEY_W-1:0];
            flag   <= cmd.evictable_flag;
            found  <= 1'b0;
            vframe <= '0;
            step   <= '0;
            addr   <= '0;
            pend   <= 1'b0;
            if (cmd.action == ACT_VICTIM) begin
              state <= (occupied == '0) ? S_DONE : S_SWEEP;
            end else if (cmd.action == ACT_PIN || cmd.action == ACT_UNPIN ||
                         cmd.action == ACT_SETEV || cmd.action == ACT_REMOVE) begin
              state <= S_LOOK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // second chance walk, one slot per cycle, at most two turns
        S_SWEEP: begin
          hand <= next_slot(hand);
          step <= step + 1'b1;
          if (valid[hand] && evict[hand] && !refb[hand]) begin
            valid[hand] <= 1'b0;
            occupied    <= occupied - 1'b1;
            state       <= S_VREAD;
          end else begin
            if (valid[hand] && evict[hand]) begin
              refb[hand] <= 1'b0;
            end
            if (step == LAST_STEP) begin
              state <= S_DONE;
            end
          end
        end
        // frame of the freed slot arrives from the store
        S_VREAD: begin
          found  <= 1'b1;
          vframe <= rdata;
          state  <= S_DONE;
        end
        // lookup scan, compared in the cycle after each read address
        S_LOOK: begin
          if (match) begin
            hit   <= 1'b1;
            idx   <= pidx;
            state <= S_APPLY;
          end else if (pend && pidx == LAST_SLOT) begin
            hit   <= 1'b0;
            state <= S_APPLY;
          end else begin
            pend <= 1'b1;
            pidx <= addr;
            addr <= addr + 1'b1;
          end
        end
        S_APPLY: begin
          state <= S_DONE;
          unique case (act)
            ACT_PIN: begin
              if (hit) begin
                evict[idx] <= 1'b0;
                refb[idx]  <= 1'b1;
              end
            end
            ACT_UNPIN: begin
              if (hit) begin
                evict[idx] <= 1'b1;
                refb[idx]  <= 1'b1;
              end else if (occupied == FULL) begin
                evict[hand] <= 1'b1;
                refb[hand]  <= 1'b1;
              end else begin
                ptr   <= hand;
                state <= S_FREE;
              end
            end
            ACT_SETEV: begin
              if (hit) begin
                evict[idx] <= flag;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                valid[idx] <= 1'b0;
                if (occupied != '0) begin
                  occupied <= occupied - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        // first empty slot at or after the hand
        S_FREE: begin
          if (!valid[ptr]) begin
            valid[ptr] <= 1'b1;
            evict[ptr] <= 1'b1;
            refb[ptr]  <= 1'b1;
            occupied   <= occupied + 1'b1;
            state      <= S_DONE;
          end else begin
            ptr <= next_slot(ptr);
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat
  assign occ_ext            = EXT_W'(occupied);
  assign cmd_ready          = (state == S_IDLE);
  assign res_valid          = (state == S_DONE);
  assign res.victim_found   = found;
  assign res.victim_frame   = FRAME_W'(vframe);
  assign res.occupied_count = occ_ext[COUNT_W-1:0];

endmodule

### hdl/clock_frame_replacer.sv
// clock_frame_replacer: top level, stream ports, output beat register and checks
// uses cfr_pkg and cfr_engine
//
// Clock (second chance) frame replacer over a ring of SLOTS slots. Each request
// beat returns exactly one result beat. A request is taken only while the
// sequencer is idle; a finished result waits in the output register so the next
// request can be taken while it is pending. One slot is examined per clock by
// the sequencer: size and unknown actions go straight to the result, as does
// victim with an empty ring; otherwise victim sweeps at most two turns of the
// ring; pin, unpin, set evictable and remove scan the frame store at one slot
// per cycle, and an unpin of a new frame that finds the ring not full adds a
// free slot search from the hand. No clearing pass is needed after reset.
module clock_frame_replacer #(
  parameter int SLOTS      = 64,
  parameter int FRAME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // frame_number[15:0], evictable_flag[16], zero pad
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // victim_found[0], victim_frame[16:1], occupied_count[23:17]
);
  import cfr_pkg::*;

  cmd_t cmd;
  res_t eng_res;
  res_t out_res;
  logic eng_done;
  logic res_take;

  // request beat unpacking
  assign cmd.action         = s_axis_tuser;
  assign cmd.frame_number   = s_axis_tdata[FRAME_W-1:0];
  assign cmd.evictable_flag = s_axis_tdata[FRAME_W];

  cfr_engine #(
    .SLOTS      (SLOTS),
    .FRAME_BITS (FRAME_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .cmd       (cmd),
    .res_valid (eng_done),
    .res_take  (res_take),
    .res       (eng_res)
  );

  // output beat register
  assign res_take = eng_done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= eng_res;
    end
  end

  assign m_axis_tdata = out_res;

  // a beat without a victim carries a zero frame
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == '0)
    else $error("result without victim carries a frame");

  // a finished result held back by the output side stays put
  assert property (@(posedge clk) disable iff (rst)
    eng_done && !res_take |=> eng_done && $stable(eng_res))
    else $error("pending engine result lost or changed");

  // no request is taken while a result is still owed by the engine
  assert property (@(posedge clk) disable iff (rst)
    eng_done |-> !s_axis_tready)
    else $error("request taken while result pending in engine");

endmodule
